/* rtl/lsm_pkg.sv */
// ---------------------------------------------------------------------------
// lsm_pkg
// Types, codes and helpers shared by the literal substring matcher.
// ---------------------------------------------------------------------------
package lsm_pkg;

    localparam int PATTERN_MAX    = 128;
    localparam int POSITION_WIDTH = 24;
    localparam int SLOT_W         = $clog2(PATTERN_MAX);
    localparam int LEN_W          = $clog2(PATTERN_MAX + 1);
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
    localparam logic [7:0] ASCII_CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_TEXT    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_MATCH     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_IDLE      = 2'd3
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CASE_EXACT     = 2'd0,
        CFG_SEARCH_REVERSE = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] slot;
        logic [7:0] byte_value;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] first_index;
        logic [23:0] last_index;
    } t_out_word;

    // upper-case fold of ASCII letters unless exact compare is selected
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
        logic [7:0] r;
        r = c;
        if (!exact && c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            r = c - ASCII_CASE_GAP;
        end
        return r;
    endfunction

endpackage

/* rtl/literal_substring_matcher.sv */
// ---------------------------------------------------------------------------
// literal_substring_matcher
// Streaming literal pattern finder with one comparator per pattern position.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_word) carries commands: load
// a pattern byte into a slot, restart the scan, or present a text byte. Each
// accepted word gives exactly one result word on the output channel
// (o_out_valid / i_out_stall / o_out_word): status plus the first and last
// stream indices of the first complete match.
// A word accepted into the input register has its result registered in the
// output register once that is free. Throughput: one word per cycle while the
// receiver does not stall; the progress vector for all positions is updated
// at once from a row of per-slot comparators.
// When the receiver stalls, the result holds in the output register and one
// further word is held in the input register; o_in_stall then rises.
// Reset clears progress, stream position, finish flag and configuration
// (folded compare, forward search, length 1). The pattern store is not
// cleared: slots must be loaded before they are used.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must do so only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module literal_substring_matcher
    import lsm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_word               i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_word              o_out_word,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic                   r_case_exact;
    logic                   r_reverse;
    logic [7:0]             r_length;
    logic                   r_in_valid;
    t_in_word               r_in_word;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    logic                   advance;
    logic                   in_take;
    logic                   load_en;
    logic [LEN_W-1:0]       len_eff;
    logic [PATTERN_MAX-1:0] hit;
    t_out_word              n_out_word;
    logic                   finished;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_exact <= 1'b0;
            r_reverse    <= 1'b0;
            r_length     <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CASE_EXACT:     r_case_exact <= i_cfg_data[0];
                CFG_SEARCH_REVERSE: r_reverse    <= i_cfg_data[0];
                CFG_PATTERN_LENGTH: r_length     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // length zero acts as one, oversize as the store depth
    always_comb begin
        priority if (r_length == 8'd0) begin
            len_eff = LEN_W'(1);
        end else if (32'(r_length) > PATTERN_MAX) begin
            len_eff = LEN_W'(PATTERN_MAX);
        end else begin
            len_eff = LEN_W'(r_length);
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign load_en    = advance && (r_in_word.command == CMD_LOAD) &&
                        (32'(r_in_word.slot) < PATTERN_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    lsm_pattern_bank u_bank (
        .i_clk        (i_clk),
        .i_wr_en      (load_en),
        .i_wr_slot    (r_in_word.slot[SLOT_W-1:0]),
        .i_wr_data    (r_in_word.byte_value),
        .i_text       (r_in_word.byte_value),
        .i_case_exact (r_case_exact),
        .o_hit        (hit)
    );

    lsm_progress u_progress (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_word     (r_in_word),
        .i_hit      (hit),
        .i_reverse  (r_reverse),
        .i_len      (len_eff),
        .o_result   (n_out_word),
        .o_finished (finished)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a reported match or not-found always closes the scan
    a_report_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (n_out_word.status == ST_MATCH || n_out_word.status == ST_NOT_FOUND)
        |=> finished)
        else $error("scan not finished after a final report");

    // indices are only non-zero on a match, and then ordered
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_word.status == ST_MATCH)
        |-> (r_out_word.last_index >= r_out_word.first_index))
        else $error("match indices out of order");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_word.status != ST_MATCH)
        |-> (r_out_word.first_index == '0) && (r_out_word.last_index == '0))
        else $error("indices set without a match");

    // a text word after the scan has finished reports idle
    a_finished_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && finished && (r_in_word.command == CMD_TEXT)
        |=> (r_out_word.status == ST_IDLE))
        else $error("text word after finish not reported idle");

endmodule

/* rtl/lsm_pattern_bank.sv */
// ---------------------------------------------------------------------------
// lsm_pattern_bank
// Pattern byte store with one comparator per position against the text byte.
// ---------------------------------------------------------------------------
module lsm_pattern_bank
    import lsm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [SLOT_W-1:0]      i_wr_slot,
    input  logic [7:0]             i_wr_data,
    input  logic [7:0]             i_text,
    input  logic                   i_case_exact,
    output logic [PATTERN_MAX-1:0] o_hit
);

    // no reset: slots are undefined until loaded
    logic [7:0] r_pattern [PATTERN_MAX];
    logic [7:0] text_folded;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pattern[i_wr_slot] <= i_wr_data;
        end
    end

    assign text_folded = fold_byte(i_text, i_case_exact);

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            o_hit[k] = (fold_byte(r_pattern[k], i_case_exact) == text_folded);
        end
    end

endmodule

/* rtl/lsm_progress.sv */
// ---------------------------------------------------------------------------
// lsm_progress
// Progress vector, stream position and finish flag; forms one result word.
// ---------------------------------------------------------------------------
module lsm_progress
    import lsm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  t_in_word               i_word,
    input  logic [PATTERN_MAX-1:0] i_hit,
    input  logic                   i_reverse,
    input  logic [LEN_W-1:0]       i_len,
    output t_out_word              o_result,
    output logic                   o_finished
);

    logic [PATTERN_MAX-1:0]    r_progress, n_progress;
    logic [POSITION_WIDTH-1:0] r_count, n_count;
    logic                      r_finished, n_finished;

    logic [PATTERN_MAX-1:0]    hit_rev;
    logic [PATTERN_MAX-1:0]    hit_sel;
    logic [PATTERN_MAX-1:0]    len_mask;
    logic [PATTERN_MAX-1:0]    scan_bits;
    logic [LEN_W-1:0]          rev_shift;
    logic [LEN_W-1:0]          len_m1;
    logic [POSITION_WIDTH-1:0] len_m1_ext;
    logic                      found;

    // reverse mode: bit j compares against pattern slot len-1-j
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            hit_rev[k] = i_hit[PATTERN_MAX-1-k];
        end
    end

    assign rev_shift  = LEN_W'(PATTERN_MAX) - i_len;
    assign hit_sel    = i_reverse ? (hit_rev >> rev_shift) : i_hit;
    assign len_mask   = ~({PATTERN_MAX{1'b1}} << i_len);
    assign scan_bits  = len_mask & hit_sel & {r_progress[PATTERN_MAX-2:0], 1'b1};
    assign len_m1     = i_len - LEN_W'(1);
    assign len_m1_ext = POSITION_WIDTH'(len_m1);
    assign found      = scan_bits[len_m1[SLOT_W-1:0]];

    always_comb begin
        n_progress = r_progress;
        n_count    = r_count;
        n_finished = r_finished;
        o_result   = '{status: ST_IDLE, first_index: '0, last_index: '0};
        unique case (i_word.command)
            CMD_RESTART: begin
                n_progress = '0;
                n_count    = '0;
                n_finished = 1'b0;
            end
            CMD_TEXT: begin
                if (!r_finished) begin
                    n_progress = scan_bits;
                    if (r_count != {POSITION_WIDTH{1'b1}}) begin
                        n_count = r_count + POSITION_WIDTH'(1);
                    end
                    if (found) begin
                        o_result.status     = ST_MATCH;
                        o_result.last_index = 24'(r_count);
                        o_result.first_index = (r_count >= len_m1_ext) ?
                                               24'(r_count - len_m1_ext) : '0;
                        n_finished = 1'b1;
                    end else if (i_word.final_byte) begin
                        o_result.status = ST_NOT_FOUND;
                        n_finished      = 1'b1;
                    end else begin
                        o_result.status = ST_NONE;
                    end
                end
            end
            default: begin
                // pattern loads and the unused code leave the scan alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_progress <= '0;
            r_count    <= '0;
            r_finished <= 1'b0;
        end else if (i_step) begin
            r_progress <= n_progress;
            r_count    <= n_count;
            r_finished <= n_finished;
        end
    end

    assign o_finished = r_finished;

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for literal_substring_matcher. Pattern loads, restarts
// and text words stream in, random and directed, under several idling mixes
// and register settings. A scoreboard predicts every result word and
// compares each one with the block's output.
// ---------------------------------------------------------------------------
module testbench;
    import lsm_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [7:0] CHAR_NL      = 8'h0a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         ITEM_TARGET  = 850;
    localparam int         PHASE_ITEMS  = 100;

    class match_scoreboard;
        logic                      exact_mode;
        logic                      reverse_mode;
        logic [7:0]                length_reg;
        logic [7:0]                pattern [PATTERN_MAX];
        logic [PATTERN_MAX-1:0]    progress;
        logic [POSITION_WIDTH-1:0] position;
        logic                      finished;
        t_out_word                 awaited [$];
        int                        errors;

        function new();
            exact_mode   = 1'b0;
            reverse_mode = 1'b0;
            length_reg   = 8'd1;
            progress     = '0;
            position     = '0;
            finished     = 1'b0;
            errors       = 0;
            foreach (pattern[k]) pattern[k] = '0;
        endfunction

        function void write_reg(input t_cfg_index idx, input logic [7:0] v);
            case (idx)
                CFG_CASE_EXACT:     exact_mode = v[0];
                CFG_SEARCH_REVERSE: reverse_mode = v[0];
                CFG_PATTERN_LENGTH: length_reg = v;
                default: ;
            endcase
        endfunction

        function logic [7:0] upcase(input logic [7:0] c);
            if (!exact_mode && c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
                return c - ASCII_CASE_GAP;
            end
            return c;
        endfunction

        function void note_input(input t_in_word w);
            t_out_word                 r;
            logic [PATTERN_MAX-1:0]    nxt;
            logic [7:0]                t;
            logic [POSITION_WIDTH-1:0] idx;
            int                        len;
            int                        j;
            int                        p;
            r = '0;
            r.status = ST_IDLE;
            case (w.command)
                CMD_LOAD: pattern[w.slot] = w.byte_value;
                CMD_RESTART: begin
                    progress = '0;
                    position = '0;
                    finished = 1'b0;
                end
                CMD_TEXT: begin
                    if (!finished) begin
                        len = (length_reg == 8'd0) ? 1 :
                              (int'(length_reg) > PATTERN_MAX) ? PATTERN_MAX :
                              int'(length_reg);
                        t = upcase(w.byte_value);
                        nxt = '0;
                        // bit j: last j+1 words agree with pattern head, or tail if reversed
                        for (j = 0; j < len; j++) begin
                            p = reverse_mode ? len - 1 - j : j;
                            nxt[j] = ((j == 0) ? 1'b1 : progress[j-1]) &&
                                     (upcase(pattern[p]) == t);
                        end
                        progress = nxt;
                        idx = position;
                        if (position != {POSITION_WIDTH{1'b1}}) position++;
                        if (progress[len-1]) begin
                            r.status = ST_MATCH;
                            r.last_index = idx;
                            r.first_index = (idx >= len - 1) ?
                                            POSITION_WIDTH'(idx - (len - 1)) : '0;
                            finished = 1'b1;
                        end else if (w.final_byte) begin
                            r.status = ST_NOT_FOUND;
                            finished = 1'b1;
                        end else begin
                            r.status = ST_NONE;
                        end
                    end
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(input t_out_word got);
            t_out_word want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result word %h with nothing expected", $time, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
            end
            if (got.first_index !== want.first_index) begin
                errors++;
                $display("%0t: first_index expected %0d actual %0d",
                         $time, want.first_index, got.first_index);
            end
            if (got.last_index !== want.last_index) begin
                errors++;
                $display("%0t: last_index expected %0d actual %0d",
                         $time, want.last_index, got.last_index);
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    t_in_word               in_word   = '0;
    logic                   out_stall = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_stall;
    logic                   out_valid;
    t_out_word              out_word;

    match_scoreboard scoreboard;

    // driver-side copy of the pattern, used to build matching text
    logic [7:0]             pat_copy [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] pat_loaded     = '0;
    logic                   cur_exact      = 1'b0;
    logic                   cur_reverse    = 1'b0;
    int                     cur_len        = 1;
    int                     send_gap_pct   = 0;
    int                     recv_stall_pct = 0;
    int                     items_sent     = 0;
    bit                     hold_armed     = 1'b0;
    int                     hold_left      = 0;
    int                     cycle_count    = 0;

    literal_substring_matcher dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) scoreboard.note_input(in_word);
        if (rst_n && out_valid === 1'b1 && !out_stall) scoreboard.check_result(out_word);
    end

    // receiver: random stalls, or a long hold-off when one is armed
    initial begin
        forever begin
            @(posedge clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    task automatic send_word(input logic [1:0] cmd, input logic [6:0] slot,
                             input logic [7:0] value, input logic last);
        t_in_word w;
        w.command    = cmd;
        w.slot       = slot;
        w.byte_value = value;
        w.final_byte = last;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        if (cmd == CMD_LOAD) begin
            pat_copy[slot]   = value;
            pat_loaded[slot] = 1'b1;
        end
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    task automatic send_text(input logic [7:0] value, input logic last);
        send_word(CMD_TEXT, 7'($urandom), value, last);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.awaited.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic exact, input logic rev, input logic [7:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CASE_EXACT;
        cfg_data  <= {7'd0, exact};
        @(posedge clk);
        cfg_index <= CFG_SEARCH_REVERSE;
        cfg_data  <= {7'd0, rev};
        @(posedge clk);
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        scoreboard.write_reg(CFG_CASE_EXACT, {7'd0, exact});
        scoreboard.write_reg(CFG_SEARCH_REVERSE, {7'd0, rev});
        scoreboard.write_reg(CFG_PATTERN_LENGTH, len);
        cur_exact   = exact;
        cur_reverse = rev;
        cur_len     = (len == 8'd0) ? 1 : (int'(len) > PATTERN_MAX) ? PATTERN_MAX : int'(len);
    endtask

    function automatic logic [7:0] pattern_char();
        case ($urandom_range(4))
            0: return ASCII_LOWER_A + 8'($urandom_range(2));
            1: return CHAR_UPPER_A + 8'($urandom_range(2));
            2: return CHAR_NL;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] c, input int pct);
        if ((c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) ||
            (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)) begin
            if ($urandom_range(99) < pct) return c ^ ASCII_CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(99);
        if (r < 50) return vary_case(pat_copy[$urandom_range(cur_len - 1)], 30);
        if (r < 60) return CHAR_NL;
        return 8'($urandom_range(255));
    endfunction

    task automatic directed_checks();
        send_word(CMD_LOAD, 7'd0, "q", 1'b0);
        send_word(CMD_LOAD, 7'd127, 8'hff, 1'b1);
        send_word(CMD_LOAD, 7'd1, CHAR_NL, 1'b0);
        send_word(CMD_LOAD, 7'd2, 8'h00, 1'b0);
        send_word(CMD_UNUSED, 7'h7f, 8'hff, 1'b1);
        send_word(CMD_RESTART, 7'd0, 8'h00, 1'b0);
        send_text("a", 1'b0);
        send_text("Q", 1'b0);
        send_text("q", 1'b0);          // after the match: ignored
        send_word(CMD_RESTART, 7'h7f, 8'hff, 1'b1);
        send_text(8'hff, 1'b1);        // not found
        send_text("q", 1'b1);
        send_word(CMD_RESTART, 7'd0, 8'h00, 1'b0);
        send_text("q", 1'b1);          // match on the final word
        wait_idle();
        configure(1'b1, 1'b0, 8'd3);
        send_word(CMD_RESTART, 7'd0, 8'h00, 1'b0);
        send_text("Q", 1'b0);
        send_text("q", 1'b0);
        send_text(CHAR_NL, 1'b0);
        send_word(CMD_LOAD, 7'd2, "z", 1'b0);   // pattern change mid-scan
        send_text("z", 1'b0);
        wait_idle();
        configure(1'b0, 1'b1, 8'd3);
        send_word(CMD_RESTART, 7'd0, 8'h00, 1'b0);
        send_text("Z", 1'b0);
        send_text(CHAR_NL, 1'b0);
        send_text("Q", 1'b1);
    endtask

    task automatic reload_pattern();
        int s;
        for (s = 0; s < cur_len; s++) begin
            if (!pat_loaded[s] || cur_len <= 16 || $urandom_range(31) == 0) begin
                send_word(CMD_LOAD, 7'(s), pattern_char(), 1'($urandom));
            end
        end
    endtask

    task automatic run_scan();
        int         lead;
        int         k;
        logic [6:0] p;
        send_word(CMD_RESTART, 7'($urandom), 8'($urandom), 1'($urandom));
        lead = $urandom_range(12);
        for (k = 0; k < lead; k++) begin
            case ($urandom_range(19))
                0: send_word(CMD_LOAD, 7'($urandom), pattern_char(), 1'($urandom));
                1: send_word(CMD_UNUSED, 7'($urandom), 8'($urandom), 1'($urandom));
                2: send_text(text_char(), 1'b1);
                default: send_text(text_char(), 1'b0);
            endcase
        end
        if ($urandom_range(3) != 0) begin
            // whole pattern in arrival order, letters in either case
            for (k = 0; k < cur_len; k++) begin
                p = 7'(cur_reverse ? cur_len - 1 - k : k);
                send_text(vary_case(pat_copy[p], cur_exact ? 5 : 50),
                          (k == cur_len - 1) && ($urandom_range(3) == 0));
            end
        end else begin
            send_text(text_char(), 1'b1);
        end
        repeat ($urandom_range(2)) send_text(text_char(), 1'($urandom));
    endtask

    initial begin
        int         phase;
        int         budget;
        int         r;
        bit         hold_done;
        logic       exact;
        logic       rev;
        logic [7:0] len;
        scoreboard = new();
        phase = 0;
        hold_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_checks();
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 68; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 68; end
                default: begin send_gap_pct = 16; recv_stall_pct = 16; end
            endcase
            case (phase)
                0: begin exact = 1'b0; rev = 1'b0; len = 8'd0;   end
                1: begin exact = 1'b1; rev = 1'b1; len = 8'd128; end
                2: begin exact = 1'b0; rev = 1'b1; len = 8'd4;   end
                3: begin exact = 1'b1; rev = 1'b0; len = 8'd255; end
                4: begin exact = 1'b0; rev = 1'b0; len = 8'd1;   end
                5: begin exact = 1'b1; rev = 1'b1; len = 8'd2;   end
                default: begin
                    exact = 1'($urandom);
                    rev = 1'($urandom);
                    r = $urandom_range(15);
                    if (r == 0) len = 8'd0;
                    else if (r == 1) len = 8'(128 + $urandom_range(127));
                    else len = 8'(1 + $urandom_range(7));
                end
            endcase
            configure(exact, rev, len);
            reload_pattern();
            budget = items_sent + PHASE_ITEMS;
            while (items_sent < budget) begin
                run_scan();
                // receiver holds off while the sender keeps offering words
                if (phase % 4 == 0 && !hold_done) begin
                    hold_armed = 1'b1;
                    hold_done = 1'b1;
                end
            end
            phase++;
        end
        wait_idle();
        if (scoreboard.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/lsm_pkg.sv
rtl/lsm_pattern_bank.sv
rtl/lsm_progress.sv
rtl/literal_substring_matcher.sv
tb/testbench.sv
